// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// S-box tables, GF(2^8) helpers and round functions shared by the cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NB_WORDS = 60;
	localparam int MAX_ROUNDS = 14;

	typedef enum logic [1:0] {
		KS_128 = 2'd0,
		KS_192 = 2'd1,
		KS_256 = 2'd2,
		KS_256X = 2'd3
	} key_size_t;

	typedef enum logic [2:0] {
		CFG_KEY_SIZE = 3'd0,
		CFG_KEY_0 = 3'd1,
		CFG_KEY_1 = 3'd2,
		CFG_KEY_2 = 3'd3,
		CFG_KEY_3 = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KX_IDLE = 2'd0,
		KX_RUN = 2'd1
	} kx_state_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] p;
		r = 8'h00;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				r = r ^ p;
			p = xtime(p);
		end
		gmul = r;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] p;
		logic [7:0] e;
		r = 8'h01;
		p = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i])
				r = gmul(r, p);
			p = gmul(p, p);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		sbox_calc = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
			^ {b[3:0], b[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [7:0] isbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
		isbox_calc = ginv(b);
	endfunction

	typedef logic [7:0] sbox_arr_t [256];

	function automatic sbox_arr_t build_sbox(input logic inv);
		sbox_arr_t t;
		for (int i = 0; i < 256; i++)
			t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
		return t;
	endfunction

	localparam sbox_arr_t SBOX = build_sbox(1'b0);
	localparam sbox_arr_t ISBOX = build_sbox(1'b1);

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// state byte k = bits [127-8k -: 8]
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (!inv)
					t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)%4)) -: 8]];
				else
					t[127-8*(r+4*((c+r)%4)) -: 8] = ISBOX[s[127-8*(r+4*c) -: 8]];
			end
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			if (!inv) begin
				t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end else begin
				t[127-32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
					^ gmul(a3, 8'd9);
				t[119-32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
					^ gmul(a3, 8'd13);
				t[111-32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
					^ gmul(a3, 8'd11);
				t[103-32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
					^ gmul(a3, 8'd14);
			end
		end
		return t;
	endfunction

endpackage

// ===== sv/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One pipeline stage: one cipher round (or pass-through) on a registered item.
// ----------------------------------------------------------------------------
module aes_round (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [4:0]   rnd,
	input  logic         nr12,
	input  logic         nr14,
	input  logic         in_vld,
	input  logic         in_dec,
	input  logic [127:0] in_st,
	input  logic [127:0] rk,
	output logic         out_vld,
	output logic         out_dec,
	output logic [127:0] out_st
);
	import aes_pkg::*;

	logic [127:0] st_nxt;
	logic         active;
	logic         last;

	// stage rnd performs round rnd (1..14); skipped when beyond the round count
	always_comb begin
		active = (rnd <= 5'd10) || (rnd <= 5'd12 && nr12) || nr14;
		last = (rnd == 5'd10 && !nr12 && !nr14) || (rnd == 5'd12 && nr12) ||
			(rnd == 5'd14);
		if (!active)
			st_nxt = in_st;
		else if (!in_dec)
			st_nxt = last ? (sub_shift(in_st, 1'b0) ^ rk)
				: (mix_cols(sub_shift(in_st, 1'b0), 1'b0) ^ rk);
		else
			st_nxt = last ? (sub_shift(in_st, 1'b1) ^ rk)
				: mix_cols(sub_shift(in_st, 1'b1) ^ rk, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		out_dec <= in_dec;
		out_st <= st_nxt;
	end

endmodule

// ===== sv/aes_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// AES block cipher top
// FIPS-197 AES-128/192/256, fully pipelined, one round per stage.
// ----------------------------------------------------------------------------
// channel | signals                          | transfer
// cfg     | cfg_we cfg_idx cfg_data          | cfg_we high
// in      | start func block_high block_low  | start && !busy
// out     | done result_high result_low      | done high, one cycle
// One item may enter every cycle while busy is low; it passes the load stage and
// 14 round stages of the round pipeline. Key writes start a schedule expansion of
// one word a cycle, restarted by a new write; busy stays high until it ends.
// Reset clears valid bits and the key registers. Results cannot be stalled.
module aes_block_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	import aes_pkg::*;

	logic [1:0]   key_size_q;
	logic [63:0]  key_q [4];
	logic [127:0] rk_q [MAX_ROUNDS+1];
	logic [31:0]  win_q [8];
	logic [31:0]  kw [8];
	logic [5:0]   kx_i_q;
	logic [7:0]   rcon_q;
	logic [2:0]   kx_j_q;
	kx_state_t    kx_state_q, kx_state_nxt;
	logic         kx_go, kx_step;
	logic         nr12, nr14;
	logic [3:0]   nk;
	logic [3:0]   nr;
	logic [5:0]   total;
	logic [31:0]  kx_t, kx_new, kx_back;
	logic [5:0]   pipe_cnt_q;

	assign nr12 = (key_size_q == KS_192);
	assign nr14 = (key_size_q == KS_256) || (key_size_q == KS_256X);
	assign nk = nr14 ? 4'd8 : (nr12 ? 4'd6 : 4'd4);
	assign nr = nr14 ? 4'd14 : (nr12 ? 4'd12 : 4'd10);
	assign total = nr14 ? 6'd60 : (nr12 ? 6'd52 : 6'd44);

	// config writes; the user must keep the pipeline empty when they occur, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= 2'd0;
			for (int i = 0; i < 4; i++)
				key_q[i] <= 64'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_KEY_SIZE: key_size_q <= cfg_data[1:0];
				CFG_KEY_0: key_q[0] <= cfg_data;
				CFG_KEY_1: key_q[1] <= cfg_data;
				CFG_KEY_2: key_q[2] <= cfg_data;
				CFG_KEY_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign kw[0] = key_q[0][63:32];
	assign kw[1] = key_q[0][31:0];
	assign kw[2] = key_q[1][63:32];
	assign kw[3] = key_q[1][31:0];
	assign kw[4] = key_q[2][63:32];
	assign kw[5] = key_q[2][31:0];
	assign kw[6] = key_q[3][63:32];
	assign kw[7] = key_q[3][31:0];

	logic kx_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kx_pend_q <= 1'b1;
		else if (cfg_we)
			kx_pend_q <= 1'b1;
		else if (kx_go)
			kx_pend_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kx_state_q <= KX_IDLE;
		else
			kx_state_q <= kx_state_nxt;
	end

	always_comb begin
		kx_go = 1'b0;
		kx_step = 1'b0;
		kx_state_nxt = kx_state_q;
		unique case (kx_state_q)
			KX_IDLE: begin
				if (kx_pend_q && !cfg_we) begin
					kx_go = 1'b1;
					kx_state_nxt = KX_RUN;
				end
			end
			KX_RUN: begin
				kx_step = 1'b1;
				if (cfg_we)
					kx_state_nxt = KX_IDLE;
				else if (kx_i_q == total - 6'd1)
					kx_state_nxt = KX_IDLE;
			end
			default: kx_state_nxt = KX_IDLE;
		endcase
	end

	// win_q[0] holds word i-1, win_q[nk-1] holds word i-nk
	always_comb begin
		kx_back = nr14 ? win_q[7] : (nr12 ? win_q[5] : win_q[3]);
		kx_t = win_q[0];
		if (kx_j_q == 3'd0)
			kx_t = sub_word({kx_t[23:0], kx_t[31:24]}) ^ {rcon_q, 24'd0};
		else if (nr14 && kx_j_q == 3'd4)
			kx_t = sub_word(kx_t);
		kx_new = kx_back ^ kx_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_i_q <= 6'd0;
			kx_j_q <= 3'd0;
			rcon_q <= 8'h01;
		end else if (kx_go) begin
			kx_i_q <= 6'(nk);
			kx_j_q <= 3'd0;
			rcon_q <= 8'h01;
		end else if (kx_step) begin
			kx_i_q <= kx_i_q + 6'd1;
			kx_j_q <= (kx_j_q == 3'(nk - 4'd1)) ? 3'd0 : kx_j_q + 3'd1;
			if (kx_j_q == 3'd0)
				rcon_q <= xtime(rcon_q);
		end
	end

	always_ff @(posedge clk) begin
		if (kx_go) begin
			rk_q[0] <= {kw[0], kw[1], kw[2], kw[3]};
			rk_q[1] <= {kw[4], kw[5], kw[6], kw[7]};
			for (int k = 0; k < 8; k++)
				win_q[k] <= nr14 ? kw[3'(7 - k)] : (nr12 ? kw[3'(5 - k)] : kw[3'(3 - k)]);
		end else if (kx_step) begin
			unique case (kx_i_q[1:0])
				2'd0: rk_q[kx_i_q[5:2]][127:96] <= kx_new;
				2'd1: rk_q[kx_i_q[5:2]][95:64] <= kx_new;
				2'd2: rk_q[kx_i_q[5:2]][63:32] <= kx_new;
				2'd3: rk_q[kx_i_q[5:2]][31:0] <= kx_new;
			endcase
			win_q[0] <= kx_new;
			for (int k = 1; k < 8; k++)
				win_q[k] <= win_q[k-1];
		end
	end

	assign busy = kx_pend_q || (kx_state_q != KX_IDLE);

	// pipeline
	logic         vld_s [MAX_ROUNDS+1];
	logic         dec_s [MAX_ROUNDS+1];
	logic [127:0] st_s  [MAX_ROUNDS+1];
	logic [127:0] rk_first, rk_last;
	logic         acc;

	assign acc = start && !busy;

	assign rk_first = rk_q[4'd0];
	assign rk_last = rk_q[nr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else
			vld_s[0] <= acc;
	end

	always_ff @(posedge clk) begin
		dec_s[0] <= func;
		st_s[0] <= {block_high, block_low} ^ (func ? rk_last : rk_first);
	end

	for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_rnd
		logic [127:0] rk;
		logic [3:0]   rk_idx;
		assign rk_idx = dec_s[g-1] ? ((4'(g) > nr) ? 4'd0 : nr - 4'(g)) : 4'(g);
		assign rk = rk_q[rk_idx];
		aes_round u_rnd (
			.clk(clk), .arst_n(arst_n), .rnd(5'(g)), .nr12(nr12), .nr14(nr14),
			.in_vld(vld_s[g-1]), .in_dec(dec_s[g-1]), .in_st(st_s[g-1]), .rk(rk),
			.out_vld(vld_s[g]), .out_dec(dec_s[g]), .out_st(st_s[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pipe_cnt_q <= 6'd0;
		else
			pipe_cnt_q <= pipe_cnt_q + 6'(acc) - 6'(vld_s[MAX_ROUNDS]);
	end

	assign done = vld_s[MAX_ROUNDS];
	assign result_high = st_s[MAX_ROUNDS][127:64];
	assign result_low = st_s[MAX_ROUNDS][63:0];

`ifndef ASSERT_OFF
	a_no_acc_in_kx: assert property (@(posedge clk) disable iff (!arst_n)
		(kx_state_q == KX_RUN) |-> !acc) else $error("transfer during expansion");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_cnt_q <= 6'(MAX_ROUNDS + 1)) else $error("pipeline overfull");
	a_done_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pipe_cnt_q != 6'd0) else $error("result without item");
`endif

endmodule
